// File: rtl/slrng_pkg.sv
// slrng_pkg: shared types and constants of the subtractive lagged generator.
// No dependencies; the interfaces and all modules import it.
package slrng_pkg;

  localparam int unsigned TableLen   = 55;
  localparam int unsigned AddrW      = 6;
  localparam int unsigned WordW      = 30;
  localparam int unsigned SeedW      = 28;
  localparam int unsigned Stride     = 21;
  localparam int unsigned WarmOffset = 30;
  localparam int unsigned LagStart   = 31;
  localparam int unsigned WarmPasses = 4;

  // partner of word j in a warm-up pass sits at (j + 31) mod 55 (0-based)
  localparam int unsigned PartnerFwd  = WarmOffset + 1;
  localparam int unsigned PartnerBack = TableLen - PartnerFwd;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [WordW-1:0] word_t;
  typedef logic [SeedW-1:0] seed_t;

  localparam word_t Modulus  = 30'd1000000000;
  localparam seed_t SeedBase = 28'd161803398;

  // one cycle of table traffic: one write port, two read ports
  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
    logic  re;
    addr_t raddr_a;
    addr_t raddr_b;
  } ram_req_t;

endpackage

// File: rtl/slrng_in_if.sv
// slrng_in_if: request channel, one beat per draw (op and seed).
// Depends on slrng_pkg.
interface slrng_in_if
  import slrng_pkg::*;
;
  logic  valid;
  logic  ready;
  logic  op;
  seed_t seed_magnitude;

  modport source (output valid, output op, output seed_magnitude, input ready);
  modport sink   (input valid, input op, input seed_magnitude, output ready);
endinterface

// File: rtl/slrng_out_if.sv
// slrng_out_if: result channel, one beat per drawn value.
// Depends on slrng_pkg.
interface slrng_out_if
  import slrng_pkg::*;
;
  logic  valid;
  logic  ready;
  word_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// File: rtl/slrng_ram.sv
// slrng_ram: 55-word lag table, one write port and two registered read ports.
// Depends on slrng_pkg.
module slrng_ram
  import slrng_pkg::*;
(
  input  logic     clk_i,
  input  ram_req_t req_i,
  output word_t    rd_a_o,
  output word_t    rd_b_o
);

  word_t mem_q [TableLen];
  word_t rd_a_q;
  word_t rd_b_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // read ports hold their data until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_a_q <= mem_q[req_i.raddr_a];
      rd_b_q <= mem_q[req_i.raddr_b];
    end
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

// File: rtl/slrng_alu.sv
// slrng_alu: shared (a - b) mod 1e9 unit for both operands below 1e9.
// Depends on slrng_pkg.
module slrng_alu
  import slrng_pkg::*;
(
  input  word_t a_i,
  input  word_t b_i,
  output word_t y_o
);

  logic [WordW:0] diff;
  logic [WordW:0] wrapped;

  // subtract, add the modulus back on borrow
  assign diff    = {1'b0, a_i} - {1'b0, b_i};
  assign wrapped = diff + {1'b0, Modulus};
  assign y_o     = diff[WordW] ? wrapped[WordW-1:0] : diff[WordW-1:0];

endmodule

// File: rtl/subtractive_lagged_rng.sv
// subtractive_lagged_rng: top level of the lag-55/24 subtractive generator.
// Depends on slrng_pkg, slrng_in_if, slrng_out_if, slrng_ram and slrng_alu.
//
// Each request beat yields one value in 0..999999999 (fraction = value / 1e9).
// A plain draw per request beat accepts the beat, reads both table words
// through the two read ports of the table memory, then subtracts, writes back
// and loads the output register. A reseed (op = 1, or the first request after
// reset) runs in front of the draw: it writes the seed word, fills 54 more
// words, and runs 4 warm-up passes of 55 words, each word read and then
// subtracted and written, all through the single modular subtractor.
// The result sits in an output register, so a new request can be taken while
// the previous value still waits; a draw only stalls at write-back when that
// register is still full. No clearing pass runs after reset.
module subtractive_lagged_rng
  import slrng_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  slrng_in_if.sink    req_i,
  slrng_out_if.source rsp_o
);

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StSeed   = 7'b0000010,
    StFill   = 7'b0000100,
    StWarmRd = 7'b0001000,
    StWarmWr = 7'b0010000,
    StDrawRd = 7'b0100000,
    StDrawWr = 7'b1000000
  } state_e;

  localparam addr_t LastAddr  = addr_t'(TableLen - 1);
  localparam addr_t IdxLast   = addr_t'(TableLen);
  localparam addr_t FillStart = addr_t'(Stride - 1);
  localparam addr_t FillWrap  = addr_t'(TableLen - 1 - Stride);
  localparam addr_t FillStep  = addr_t'(Stride);
  localparam addr_t FillBack  = addr_t'(TableLen - Stride);
  localparam addr_t PartFwd   = addr_t'(PartnerFwd);
  localparam addr_t PartBack  = addr_t'(PartnerBack);
  localparam addr_t LagInit   = addr_t'(LagStart);
  localparam logic [1:0] PassLast = 2'(WarmPasses - 1);

  state_e     state_q, state_d;
  seed_t      seed_q, seed_d;
  word_t      cur_q, cur_d;
  word_t      nxt_q, nxt_d;
  addr_t      pos_q, pos_d;
  addr_t      step_q, step_d;
  logic [1:0] pass_q, pass_d;
  addr_t      read_q, read_d;
  addr_t      lag_q, lag_d;
  logic       seeded_q, seeded_d;
  logic       out_valid_q, out_valid_d;
  word_t      value_q, value_d;

  ram_req_t ram_req;
  word_t    rd_a, rd_b;
  word_t    alu_a, alu_b, alu_y;
  seed_t    seed_abs;
  addr_t    partner;
  addr_t    read_nx, lag_nx;
  logic     in_fire;
  logic     out_free;

  slrng_ram u_ram (
    .clk_i  (clk_i),
    .req_i  (ram_req),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  // fill runs on the cur/nxt registers, everything else on table words
  assign alu_a = (state_q == StFill) ? cur_q : rd_a;
  assign alu_b = (state_q == StFill) ? nxt_q : rd_b;

  slrng_alu u_alu (
    .a_i (alu_a),
    .b_i (alu_b),
    .y_o (alu_y)
  );

  // seed word: |base - seed|, always below the modulus for 28-bit seeds
  assign seed_abs = (seed_q > SeedBase) ? (seed_q - SeedBase) : (SeedBase - seed_q);

  // warm-up partner address (j + 31) mod 55
  assign partner = (step_q >= PartBack) ? (step_q - PartBack) : (step_q + PartFwd);

  // ring indices step 1..55 and wrap to 1
  assign read_nx = (read_q >= IdxLast || read_q == '0) ? addr_t'(1) : read_q + addr_t'(1);
  assign lag_nx  = (lag_q >= IdxLast || lag_q == '0) ? addr_t'(1) : lag_q + addr_t'(1);

  assign req_i.ready = (state_q == StIdle);
  assign in_fire     = req_i.valid && (state_q == StIdle);
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.value = value_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    seed_d      = seed_q;
    cur_d       = cur_q;
    nxt_d       = nxt_q;
    pos_d       = pos_q;
    step_d      = step_q;
    pass_d      = pass_q;
    read_d      = read_q;
    lag_d       = lag_q;
    seeded_d    = seeded_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    value_d     = value_q;
    ram_req     = '0;

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          seed_d  = req_i.seed_magnitude;
          state_d = (req_i.op || !seeded_q) ? StSeed : StDrawRd;
        end
      end
      StSeed: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = LastAddr;
        ram_req.wdata = word_t'(seed_abs);
        cur_d   = word_t'(seed_abs);
        nxt_d   = word_t'(1);
        pos_d   = FillStart;
        step_d  = addr_t'(1);
        state_d = StFill;
      end
      StFill: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = pos_q;
        ram_req.wdata = nxt_q;
        nxt_d = alu_y;
        cur_d = nxt_q;
        pos_d = (pos_q >= FillWrap) ? (pos_q - FillBack) : (pos_q + FillStep);
        if (step_q == LastAddr) begin
          step_d  = '0;
          pass_d  = '0;
          state_d = StWarmRd;
        end else begin
          step_d = step_q + addr_t'(1);
        end
      end
      StWarmRd: begin
        ram_req.re      = 1'b1;
        ram_req.raddr_a = step_q;
        ram_req.raddr_b = partner;
        state_d = StWarmWr;
      end
      StWarmWr: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = step_q;
        ram_req.wdata = alu_y;
        if (step_q == LastAddr) begin
          step_d = '0;
          if (pass_q == PassLast) begin
            read_d   = '0;
            lag_d    = LagInit;
            seeded_d = 1'b1;
            state_d  = StDrawRd;
          end else begin
            pass_d  = pass_q + 2'd1;
            state_d = StWarmRd;
          end
        end else begin
          step_d  = step_q + addr_t'(1);
          state_d = StWarmRd;
        end
      end
      StDrawRd: begin
        ram_req.re      = 1'b1;
        ram_req.raddr_a = read_nx - addr_t'(1);
        ram_req.raddr_b = lag_nx - addr_t'(1);
        read_d  = read_nx;
        lag_d   = lag_nx;
        state_d = StDrawWr;
      end
      StDrawWr: begin
        // hold the word until the output register can take it
        if (out_free) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = read_q - addr_t'(1);
          ram_req.wdata = alu_y;
          value_d     = alu_y;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      pass_q      <= '0;
      read_q      <= '0;
      lag_q       <= LagInit;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      pass_q      <= pass_d;
      read_q      <= read_d;
      lag_q       <= lag_d;
      seeded_q    <= seeded_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    seed_q  <= seed_d;
    cur_q   <= cur_d;
    nxt_q   <= nxt_d;
    pos_q   <= pos_d;
    value_q <= value_d;
  end

endmodule
